// ===== design/fmp_pkg.sv =====
package fmp_pkg;

  // modulus and montgomery constants (radix 2^32)
  localparam logic [29:0] FIB_PRIME  = 30'd1000000007;
  localparam logic [29:0] MONT_ONE   = 30'd294967268;  // 2^32 mod prime
  localparam logic [30:0] PRIME_X2   = 31'd2000000014;

  // -prime^-1 mod 2^32 by newton iteration, five steps give 96 good bits
  function automatic logic [31:0] mont_neg_inv();
    logic [31:0] p32;
    logic [31:0] inv;
    p32 = 32'(FIB_PRIME);
    inv = p32;
    for (int i = 0; i < 5; i++) begin
      inv = inv * (32'd2 - p32 * inv);
    end
    return 32'd0 - inv;
  endfunction

  localparam logic [31:0] MONT_PINV = mont_neg_inv();

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SQR  = 4'b0100,
    ST_CONV = 4'b1000
  } state_e;

  typedef enum logic [6:0] {
    PH_MUL0 = 7'b0000001,
    PH_MUL1 = 7'b0000010,
    PH_SUM  = 7'b0000100,
    PH_QUOT = 7'b0001000,
    PH_QP   = 7'b0010000,
    PH_SHR  = 7'b0100000,
    PH_FIX  = 7'b1000000
  } phase_e;

endpackage

// ===== design/fibonacci_mod_matrix_power_core.sv =====
// Fibonacci modulo 1000000007. Each input transaction carries an index n and
// produces one output transaction with F(n) mod 1000000007. Internally the
// 2x2 generator [1,1;1,0] is raised to the power n-1 by square-and-multiply
// over the exponent bits, least significant first, all in Montgomery form
// (radix 2^32) so no divider is needed. A single 32x32 multiplier is shared
// by everything: each matrix entry runs through two products, their sum, the
// Montgomery quotient, quotient times prime, add/shift and final subtract,
// and one matrix product works through its four entries in turn. n = 0 and
// n = 1 go straight to the conversion out of Montgomery form. in_stall_o is
// high while an item is being computed; the result sits in an output
// register, so a new index is taken as soon as the result has moved into
// it, even while that result still waits to be taken.
module fibonacci_mod_matrix_power_core import fmp_pkg::*; #(
  parameter int unsigned INDEX_BITS = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [29:0]           fib_value_o
);

  // sequencer
  state_e                state_q;
  phase_e                ph_q;
  logic [1:0]            ent_q;     // matrix entry under work, row-major
  logic [INDEX_BITS-1:0] k_q;       // remaining exponent bits

  // matrices in montgomery form
  logic [29:0]           acc_q [4];
  logic [29:0]           gen_q [4];
  logic [29:0]           res_q [3]; // finished entries of the product

  // shared multiplier and reduction datapath
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic                  mul_en;
  logic [63:0]           prod_q;
  logic [59:0]           part_q;
  logic [60:0]           tsum_q;
  logic [62:0]           redc_sum;
  logic [30:0]           u_q;
  logic [29:0]           red;

  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [29:0]           fib_q;

  logic                  in_fire;
  logic                  out_free;
  logic                  busy;
  logic                  last_ent;
  logic [INDEX_BITS-1:0] k_start;
  logic [29:0]           a_ent;
  logic [29:0]           b_ent;
  logic                  sel_hi;
  state_e                after_prod;

  // which product comes next, from the exponent bits still left
  function automatic state_e pick_next(logic [INDEX_BITS-1:0] kk);
    if (kk[0]) begin
      return ST_MUL;
    end else if (kk != '0) begin
      return ST_SQR;
    end else begin
      return ST_CONV;
    end
  endfunction

  function automatic phase_e phase_step(phase_e ph);
    case (ph)
      PH_MUL0: return PH_MUL1;
      PH_MUL1: return PH_SUM;
      PH_SUM:  return PH_QUOT;
      PH_QUOT: return PH_QP;
      PH_QP:   return PH_SHR;
      PH_SHR:  return PH_FIX;
      default: return PH_MUL0;
    endcase
  endfunction

  assign busy        = (state_q != ST_IDLE);
  assign in_stall_o  = busy;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign fib_value_o = fib_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_ent    = (ent_q == 2'd3);
  assign k_start     = index_i - INDEX_BITS'(1);

  // after acc*gen the square follows only if higher exponent bits remain;
  // after a square the exponent shifts and the next bit decides
  assign after_prod = (state_q == ST_MUL) ?
                      (((k_q >> 1) != '0) ? ST_SQR : ST_CONV) :
                      pick_next(k_q >> 1);

  // operand fetch: first product of the entry uses column 0 of row i of a
  // and row 0 of b, the second uses column 1 / row 1
  assign sel_hi = (ph_q == PH_MUL1);

  always_comb begin
    a_ent = '0;
    b_ent = '0;
    case (state_q)
      ST_MUL: begin
        a_ent = acc_q[{ent_q[1], sel_hi}];
        b_ent = gen_q[{sel_hi, ent_q[0]}];
      end
      ST_SQR: begin
        a_ent = gen_q[{ent_q[1], sel_hi}];
        b_ent = gen_q[{sel_hi, ent_q[0]}];
      end
      ST_CONV: begin
        // leave montgomery form: redc(acc[0] * 1)
        a_ent = sel_hi ? 30'd0 : acc_q[0];
        b_ent = sel_hi ? 30'd0 : 30'd1;
      end
      default: begin
        a_ent = '0;
        b_ent = '0;
      end
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (ph_q)
      PH_MUL0, PH_MUL1: begin
        mul_a  = 32'(a_ent);
        mul_b  = 32'(b_ent);
        mul_en = busy;
      end
      PH_QUOT: begin
        // montgomery quotient m = t * (-p^-1) mod 2^32
        mul_a  = tsum_q[31:0];
        mul_b  = MONT_PINV;
        mul_en = busy;
      end
      PH_QP: begin
        mul_a  = prod_q[31:0];
        mul_b  = 32'(FIB_PRIME);
        mul_en = busy;
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  // t + m*p is divisible by 2^32, the quotient stays below twice the prime
  assign redc_sum = 63'(tsum_q) + 63'(prod_q[61:0]);
  assign red      = (u_q >= 31'(FIB_PRIME)) ? 30'(u_q - 31'(FIB_PRIME)) : u_q[29:0];

  // output register: cleared when taken, loaded when a conversion finishes
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == ST_CONV && ph_q == PH_FIX && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_MUL0;
      ent_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ph_q  <= PH_MUL0;
            ent_q <= 2'd0;
            if (index_i == '0) begin
              state_q <= ST_CONV;
            end else begin
              state_q <= pick_next(k_start);
            end
          end
        end
        ST_MUL, ST_SQR: begin
          ph_q <= phase_step(ph_q);
          if (ph_q == PH_FIX) begin
            ent_q <= ent_q + 2'd1;
            if (last_ent) begin
              state_q <= after_prod;
            end
          end
        end
        ST_CONV: begin
          if (ph_q == PH_FIX) begin
            // hold the finished value until the output register frees up
            if (out_free) begin
              state_q <= ST_IDLE;
              ph_q    <= PH_MUL0;
            end
          end else begin
            ph_q <= phase_step(ph_q);
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ph_q    <= PH_MUL0;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      k_q      <= k_start;
      // identity accumulator, or zero so that n = 0 converts straight to 0
      acc_q[0] <= (index_i == '0) ? 30'd0 : MONT_ONE;
      acc_q[1] <= 30'd0;
      acc_q[2] <= 30'd0;
      acc_q[3] <= MONT_ONE;
      gen_q[0] <= MONT_ONE;
      gen_q[1] <= MONT_ONE;
      gen_q[2] <= MONT_ONE;
      gen_q[3] <= 30'd0;
    end
    if (mul_en) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (busy && ph_q == PH_MUL1) begin
      part_q <= prod_q[59:0];
    end
    if (busy && ph_q == PH_SUM) begin
      tsum_q <= 61'(part_q) + 61'(prod_q[59:0]);
    end
    if (busy && ph_q == PH_SHR) begin
      u_q <= redc_sum[62:32];
    end
    if (ph_q == PH_FIX) begin
      if (state_q == ST_MUL || state_q == ST_SQR) begin
        if (!last_ent) begin
          res_q[ent_q] <= red;
        end else if (state_q == ST_MUL) begin
          acc_q[0] <= res_q[0];
          acc_q[1] <= res_q[1];
          acc_q[2] <= res_q[2];
          acc_q[3] <= red;
        end else begin
          gen_q[0] <= res_q[0];
          gen_q[1] <= res_q[1];
          gen_q[2] <= res_q[2];
          gen_q[3] <= red;
          k_q      <= k_q >> 1;
        end
      end else if (state_q == ST_CONV && out_free) begin
        fib_q <= red;
      end
    end
  end

  // a taken index always starts a computation
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted index did not start a computation");

  // montgomery quotient stays below twice the prime before the final subtract
  a_redc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && ph_q == PH_FIX) |-> (u_q < PRIME_X2))
    else $error("montgomery reduction out of range");

  // a square is only scheduled while higher exponent bits remain
  a_sqr_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQR && ph_q == PH_FIX && last_ent) |-> ((k_q >> 1) != '0))
    else $error("square scheduled with no exponent bits left");

  // a delivered value is fully reduced
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fib_value_o < FIB_PRIME))
    else $error("result not reduced modulo the prime");

endmodule

// ===== sim/tb_fibonacci_mod_matrix_power_core.sv =====
`timescale 1ns / 100ps

// self-checking bench for the fibonacci mod 1e9+7 core
module tb_fibonacci_mod_matrix_power_core import fmp_pkg::*;;

  localparam int unsigned INDEX_BITS   = 63;
  localparam int unsigned RANDOM_ITEMS = 1450;
  // even if every item took as long as the slowest legal one (full 63-bit
  // index) plus stalls and gaps, 1474 items stay well below this bound
  localparam longint unsigned CYCLE_LIMIT  = 64'd20_000_000;
  // quiet cycles after the last result to catch stray output transactions
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [29:0]           fib_t;

  // 2x2 matrix mod prime, entries always reduced below the prime
  typedef struct packed {
    fib_t m00;
    fib_t m01;
    fib_t m10;
    fib_t m11;
  } fib_mat_t;

  // one pending result with the index that caused it, for messages
  typedef struct {
    index_t n;
    fib_t   fib_value;
  } fib_pending_t;

  // clock, reset and dut inputs, all known from time zero
  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  index_t index_i     = '0;
  logic   out_stall_i = 1'b0;
  logic   in_stall_o;
  logic   out_valid_o;
  fib_t   fib_value_o;

  fib_pending_t    fib_expected_q[$];
  fib_pending_t    fib_head;
  int unsigned     fail_count  = 0;
  longint unsigned cycle_count = 0;

  // receiver stall pattern state
  int unsigned stall_mode  = 0;
  int unsigned stall_timer = 0;

  fibonacci_mod_matrix_power_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .index_i     (index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .fib_value_o (fib_value_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // prediction: plain binary exponentiation of [1,1;1,0] mod the prime
  // ---------------------------------------------------------------------

  // (a*b + c*d) mod prime; products stay below 2^60 so 64 bits suffice
  function automatic fib_t dot_mod_prime(input fib_t a, input fib_t b,
                                         input fib_t c, input fib_t d);
    logic [63:0] sum;
    sum = 64'(a) * 64'(b) + 64'(c) * 64'(d);
    return fib_t'(sum % 64'(FIB_PRIME));
  endfunction

  function automatic fib_mat_t mat_product_mod(input fib_mat_t x, input fib_mat_t y);
    fib_mat_t r;
    r.m00 = dot_mod_prime(x.m00, y.m00, x.m01, y.m10);
    r.m01 = dot_mod_prime(x.m00, y.m01, x.m01, y.m11);
    r.m10 = dot_mod_prime(x.m10, y.m00, x.m11, y.m10);
    r.m11 = dot_mod_prime(x.m10, y.m01, x.m11, y.m11);
    return r;
  endfunction

  // F(n) mod prime, every call starts from a fresh generator and identity
  function automatic fib_t fib_mod_prime(input index_t n);
    fib_mat_t power;
    fib_mat_t step;
    index_t   exponent;
    if (n == '0) begin
      return '0;
    end
    power    = '{m00: 30'd1, m01: 30'd0, m10: 30'd0, m11: 30'd1};
    step     = '{m00: 30'd1, m01: 30'd1, m10: 30'd1, m11: 30'd0};
    exponent = n - index_t'(1);
    for (int b = 0; b < INDEX_BITS; b++) begin
      if (exponent[b]) begin
        power = mat_product_mod(power, step);
      end
      step = mat_product_mod(step, step);
    end
    return power.m00;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // random index, mostly short since block time grows with bit length;
  // a few wide ones, up to full width, so every index bit toggles
  function automatic index_t random_index();
    logic [63:0] raw;
    int unsigned width;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      width = $urandom_range(1, 10);
    end else if (pick < 95) begin
      width = $urandom_range(11, 32);
    end else begin
      width = $urandom_range(33, INDEX_BITS);
    end
    raw = {$urandom(), $urandom()};
    raw = raw & ((64'd1 << width) - 64'd1);
    return index_t'(raw);
  endfunction

  // called at a rising edge; holds valid until the transaction is taken and
  // returns at the accepting edge with valid still high, so a following
  // call keeps it asserted without a glitch
  task automatic send_index(input index_t n);
    in_valid_i <= 1'b1;
    index_i    <= n;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    fib_expected_q.push_back('{n: n, fib_value: fib_mod_prime(n)});
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // edge indices, fast paths back to back, a value past the prime, the
  // pisano period of the prime, and patterns that toggle every index bit
  task automatic test_directed_indices();
    index_t corner_list[$];
    corner_list = '{
      index_t'(0), index_t'(1), index_t'(0), index_t'(1),   // zero index and fast path
      index_t'(2), index_t'(3), index_t'(4), index_t'(5),
      index_t'(10),
      index_t'(44), index_t'(45), index_t'(46),             // first wrap past the prime
      index_t'(1000),
      index_t'(64'd1000000007),
      index_t'(64'd2000000016), index_t'(64'd2000000017),   // pisano period
      index_t'(64'd1) << 31, index_t'(64'd1) << 32,
      index_t'(64'd1) << (INDEX_BITS - 1),
      {INDEX_BITS{1'b1}},                                   // largest index
      index_t'({(INDEX_BITS + 1) / 2{2'b01}}),
      index_t'({(INDEX_BITS + 1) / 2{2'b10}})
    };
    foreach (corner_list[i]) begin
      send_index(corner_list[i]);
    end
    idle_sender(1);
  endtask

  // bursts of random length separated by random gaps, sometimes none
  task automatic test_random_indices(input int unsigned count);
    int unsigned sent;
    int unsigned burst_len;
    sent = 0;
    while (sent < count) begin
      burst_len = $urandom_range(1, 24);
      for (int i = 0; i < burst_len && sent < count; i++) begin
        send_index(random_index());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 8));
      end
    end
    idle_sender(1);
  endtask

  // sender holds off until the result queue is empty, then resumes
  task automatic test_pause_until_drained();
    in_valid_i <= 1'b0;
    while (fib_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    send_index(index_t'(7));
    send_index({INDEX_BITS{1'b1}});
    idle_sender(1);
  endtask

  // ---------------------------------------------------------------------
  // receiver: stall pattern that switches between free flow, light random
  // stalls and heavy stalls
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_timer = $urandom_range(50, 300);
    end else begin
      stall_timer = stall_timer - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // result checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fib_expected_q.size() == 0) begin
        $error("fib_value: unexpected output transaction, actual %0d", fib_value_o);
        fail_count++;
      end else begin
        fib_head = fib_expected_q.pop_front();
        if (fib_value_o !== fib_head.fib_value) begin
          $error("fib_value (index %0d): expected %0d, actual %0d",
                 fib_head.n, fib_head.fib_value, fib_value_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_indices();
    test_random_indices(RANDOM_ITEMS / 2);
    test_pause_until_drained();
    test_random_indices(RANDOM_ITEMS - RANDOM_ITEMS / 2);

    // drain, then watch for stray output transactions
    while (fib_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && fib_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
